>>> rtl/core/tbe_pkg.sv
// tbe_pkg: shared types, constants and the round-sum function for the tea block encryptor
// used by tbe_half_stage and tea_block_encrypt; no dependencies
`timescale 1ns / 1ps

package tbe_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA   = 32'h9e37_79b9;
    localparam int unsigned       SHIFT_LEFT  = 4;
    localparam int unsigned       SHIFT_RIGHT = 5;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t left;
        word_t right;
    } block_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } cfg_index_t;

    // running sum after round r (counting from zero), wrapped to one word
    function automatic word_t round_sum(int unsigned r);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(r + 1);
        return prod[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/core/tea_block_encrypt.sv
// tea_block_encrypt: top level of the pipelined tea block encryptor with key registers
// depends on tbe_pkg and tbe_half_stage
`timescale 1ns / 1ps

// Encrypts one 64-bit block per request with 32 rounds of tea under a 128-bit key held in
// four key registers written through the cfg port (index 0 to 3). Each round is split into
// two registered half-round stages, 64 stages in all, that each request passes through in
// order; a new request can be taken every cycle unless back-pressure has reached the input.
// Each stage holds its request until the next one is free, so a stall at the output fills
// bubbles before it pushes back on the input. Write keys only while no request is in flight.

module tea_block_encrypt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [31:0]                       plaintext_left,
    input  logic [31:0]                       plaintext_right,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [31:0]                       ciphertext_left,
    output logic [31:0]                       ciphertext_right,
    input  logic                              cfg_write_en,
    input  logic [tbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data
);

    tbe_pkg::word_t  key_word_0_reg;
    tbe_pkg::word_t  key_word_1_reg;
    tbe_pkg::word_t  key_word_2_reg;
    tbe_pkg::word_t  key_word_3_reg;

    logic            stage_valid [0:tbe_pkg::STAGE_COUNT];
    logic            stage_ready [0:tbe_pkg::STAGE_COUNT];
    tbe_pkg::block_t stage_block [0:tbe_pkg::STAGE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_0_reg <= '0;
            key_word_1_reg <= '0;
            key_word_2_reg <= '0;
            key_word_3_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (tbe_pkg::cfg_index_t'(cfg_index))
                tbe_pkg::KEY_WORD_0: key_word_0_reg <= cfg_data;
                tbe_pkg::KEY_WORD_1: key_word_1_reg <= cfg_data;
                tbe_pkg::KEY_WORD_2: key_word_2_reg <= cfg_data;
                tbe_pkg::KEY_WORD_3: key_word_3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign stage_valid[0]       = in_valid;
    assign in_ready             = stage_ready[0];
    assign stage_block[0].left  = plaintext_left;
    assign stage_block[0].right = plaintext_right;

    genvar i;
    generate
        for (i = 0; i < tbe_pkg::STAGE_COUNT; i++)
        begin : g_stage
            localparam logic IS_RIGHT = ((i % 2) == 1);

            tbe_half_stage u_stage (
                .clk          (clk),
                .rst_n        (rst_n),
                .in_valid     (stage_valid[i]),
                .in_ready     (stage_ready[i]),
                .in_block     (stage_block[i]),
                .out_valid    (stage_valid[i+1]),
                .out_ready    (stage_ready[i+1]),
                .out_block    (stage_block[i+1]),
                .sum          (tbe_pkg::round_sum(i / 2)),
                .update_right (IS_RIGHT),
                .key_a        (IS_RIGHT ? key_word_2_reg : key_word_0_reg),
                .key_b        (IS_RIGHT ? key_word_3_reg : key_word_1_reg)
            );
        end
    endgenerate

    assign stage_ready[tbe_pkg::STAGE_COUNT] = out_ready;
    assign out_valid        = stage_valid[tbe_pkg::STAGE_COUNT];
    assign ciphertext_left  = stage_block[tbe_pkg::STAGE_COUNT].left;
    assign ciphertext_right = stage_block[tbe_pkg::STAGE_COUNT].right;

endmodule

>>> rtl/core/tbe_half_stage.sv
// tbe_half_stage: one registered half-round of tea with a valid/ready stage handshake
// depends on tbe_pkg
`timescale 1ns / 1ps

module tbe_half_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tbe_pkg::block_t in_block,
    output logic            out_valid,
    input  logic            out_ready,
    output tbe_pkg::block_t out_block,
    input  tbe_pkg::word_t  sum,
    input  logic            update_right,
    input  tbe_pkg::word_t  key_a,
    input  tbe_pkg::word_t  key_b
);

    logic            valid_reg;
    logic            valid_next;
    tbe_pkg::block_t block_reg;
    tbe_pkg::block_t block_next;
    tbe_pkg::word_t  src;
    tbe_pkg::word_t  mix;
    logic            load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // mix of the half that does not change this step
    always_comb
    begin
        src = update_right ? in_block.left : in_block.right;
        mix = ((src << tbe_pkg::SHIFT_LEFT) + key_a)
            ^ (src + sum)
            ^ ((src >> tbe_pkg::SHIFT_RIGHT) + key_b);
        block_next = in_block;
        if (update_right)
        begin
            block_next.right = in_block.right + mix;
        end
        else
        begin
            block_next.left = in_block.left + mix;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            block_reg <= block_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule

>>> tb/sv/tea_block_encrypt_tb.sv
// tea_block_encrypt_tb: self-checking testbench for the pipelined tea block encryptor
// predicts each ciphertext block from the key words it writes and compares it at the output
// depends on tbe_pkg and tea_block_encrypt
`timescale 1ns / 1ps

module tea_block_encrypt_tb;

    import tbe_pkg::*;

    class tea_cipher_check;
        word_t  key[4];
        block_t ciphertexts_due[$];
        int unsigned mismatches;

        function new();
            key = '{default: '0};
            mismatches = 0;
        endfunction

        function void set_key(cfg_index_t idx, word_t v);
            key[idx] = v;
        endfunction

        function block_t tea_encrypt(word_t pl, word_t pr);
            word_t l;
            word_t r;
            word_t s;
            block_t c;
            l = pl;
            r = pr;
            s = '0;
            for (int unsigned i = 0; i < ROUND_COUNT; i++)
            begin
                s += TEA_DELTA;
                l += ((r << SHIFT_LEFT) + key[KEY_WORD_0]) ^ (r + s)
                     ^ ((r >> SHIFT_RIGHT) + key[KEY_WORD_1]);
                r += ((l << SHIFT_LEFT) + key[KEY_WORD_2]) ^ (l + s)
                     ^ ((l >> SHIFT_RIGHT) + key[KEY_WORD_3]);
            end
            c.left = l;
            c.right = r;
            return c;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_plaintext(word_t pl, word_t pr);
            ciphertexts_due.push_back(tea_encrypt(pl, pr));
        endfunction

        task check_ciphertext(word_t cl, word_t cr);
            block_t want;
            if (ciphertexts_due.size() == 0)
            begin
                report($sformatf("unexpected ciphertext %h %h", cl, cr));
                return;
            end
            want = ciphertexts_due.pop_front();
            if (cl !== want.left)
                report($sformatf("ciphertext_left %h, want %h", cl, want.left));
            if (cr !== want.right)
                report($sformatf("ciphertext_right %h, want %h", cr, want.right));
        endtask

        task flush_check();
            if (ciphertexts_due.size() != 0)
                report($sformatf("%0d ciphertext blocks never came out",
                                 ciphertexts_due.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    word_t      plaintext_left;
    word_t      plaintext_right;
    logic       out_valid;
    logic       out_ready;
    word_t      ciphertext_left;
    word_t      ciphertext_right;
    logic       cfg_write_en;
    cfg_index_t cfg_index;
    word_t      cfg_data;

    tea_cipher_check cipher_chk;
    bit              steady = 1'b0;
    int unsigned     hold_off_len = 0;

    tea_block_encrypt dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .plaintext_left   (plaintext_left),
        .plaintext_right  (plaintext_right),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .ciphertext_left  (ciphertext_left),
        .ciphertext_right (ciphertext_right),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                cipher_chk.note_plaintext(plaintext_left, plaintext_right);
            if (out_valid && out_ready)
                cipher_chk.check_ciphertext(ciphertext_left, ciphertext_right);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(negedge clk);
                hold_off_len = 0;
            end
            out_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    task automatic send_block(input word_t pl, input word_t pr);
        if (!steady)
        begin
            while ($urandom_range(99) < 31)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid        <= 1'b1;
        plaintext_left  <= pl;
        plaintext_right <= pr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_key(input cfg_index_t idx, input word_t v);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        cipher_chk.set_key(idx, v);
        @(negedge clk);
    endtask

    task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
        in_valid <= 1'b0;
        @(negedge clk);
        while (cipher_chk.ciphertexts_due.size() != 0) @(negedge clk);
        write_key(KEY_WORD_0, k0);
        write_key(KEY_WORD_1, k1);
        write_key(KEY_WORD_2, k2);
        write_key(KEY_WORD_3, k3);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_corners();
        send_block(32'h0000_0000, 32'h0000_0000);
        send_block(32'hffff_ffff, 32'hffff_ffff);
        send_block(32'h0000_0000, 32'hffff_ffff);
        send_block(32'hffff_ffff, 32'h0000_0000);
        send_block(32'h8000_0000, 32'h0000_0001);
        send_block(32'h0000_0001, 32'h8000_0000);
        send_block(32'haaaa_aaaa, 32'h5555_5555);
        send_block(32'h5555_5555, 32'haaaa_aaaa);
    endtask

    initial
    begin
        int unsigned wait_cycles;
        cipher_chk      = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        plaintext_left  = '0;
        plaintext_right = '0;
        cfg_write_en    = 1'b0;
        cfg_index       = KEY_WORD_0;
        cfg_data        = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero key straight out of reset, then the all-ones key
        send_corners();
        load_key('1, '1, '1, '1);
        send_corners();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_key($urandom, $urandom, $urandom, $urandom);
                1: load_key('1, '0, '1, '0);
                2: load_key($urandom, $urandom, $urandom, $urandom);
                default: load_key('0, '0, '0, '0);
            endcase
            for (int n = 0; n < 185; n++)
            begin
                if (phase == 0 && n == 20)
                    hold_off_len = 300;
                steady = (phase == 1 && n >= 40 && n < 120);
                send_block(pick_word(), pick_word());
            end
            steady = 1'b0;
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (cipher_chk.ciphertexts_due.size() != 0 && wait_cycles < 20000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);
        cipher_chk.flush_check();

        if (cipher_chk.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
